// File: rtl/fyshuf_pkg.sv
// fyshuf_pkg: shared types and constants for the shuffle unit
`timescale 1ns / 1ps
`default_nettype none

package fyshuf_pkg;

  // fixed field widths
  localparam int FIELD_W = 10;
  localparam int LEN_W   = 11;

  // length register after reset
  localparam int LEN_RESET = 1024;

  // byte address of the length register
  localparam logic [1:0] LEN_ADDR = 2'd0;

  // run tag stored with each entry; tag zero means never written
  localparam int EPOCH_W = 8;

  // controller states
  typedef enum logic [1:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_SWAP
  } fys_state_t;

endpackage

`default_nettype wire

// File: rtl/fisher_yates_mask_reject_shuffle_unit.sv
// fisher_yates_mask_reject_shuffle_unit: descending shuffle over a tagged slot memory
`timescale 1ns / 1ps
`default_nettype none

// channel   | direction | handshake                    | payload
// ----------+-----------+------------------------------+-----------------------------------
// input     | in        | in_valid / in_ready          | random_word
// output    | out       | out_valid / out_ready        | slot_position, slot_value, last_slot
// config    | in        | psel, penable, pwrite, pready| paddr, pwdata, prdata (perm_length)
//
// An accepted word is handled in order: the cursor and j entries are first read from the
// two read ports of the slot memory, then the swap writes j back and loads the result.
// A rejected word is taken from the input but gives no output transfer.
// The end of a run loads two results; the second drains from a holding register.
// After reset, and after every 255th rearm, a clearing pass over all MAX_LEN slots resets
// the run tags; no word is taken meanwhile. A stalled output blocks new words.

module fisher_yates_mask_reject_shuffle_unit #(
  parameter int MAX_LEN = 1024
) (
  input  wire logic                             clk,
  input  wire logic                             rst,
  // input channel
  input  wire logic                             in_valid,
  output logic                                  in_ready,
  input  wire logic [31:0]                      random_word,
  // output channel
  output logic                                  out_valid,
  input  wire logic                             out_ready,
  output logic [fyshuf_pkg::FIELD_W-1:0]        slot_position,
  output logic [fyshuf_pkg::FIELD_W-1:0]        slot_value,
  output logic                                  last_slot,
  // configuration port
  input  wire logic                             psel,
  input  wire logic                             penable,
  input  wire logic                             pwrite,
  input  wire logic [1:0]                       paddr,
  input  wire logic [31:0]                      pwdata,
  output logic [31:0]                           prdata,
  output logic                                  pready
);

  import fyshuf_pkg::*;

  localparam int AW    = (MAX_LEN > 2) ? $clog2(MAX_LEN) : 1;
  localparam int ENT_W = EPOCH_W + AW;
  localparam int RESET_LEN = (LEN_RESET < MAX_LEN) ? LEN_RESET : MAX_LEN;
  localparam logic [AW-1:0] RESET_CURSOR = AW'(RESET_LEN - 1);
  localparam logic [AW-1:0] LAST_ADDR    = AW'(MAX_LEN - 1);
  localparam logic [AW-1:0] ONE_POS      = AW'(1);

  // registers
  fys_state_t            state, state_next;
  logic [LEN_W-1:0]      perm_length;
  logic [AW-1:0]         cursor;
  logic [EPOCH_W-1:0]    epoch;
  logic [AW-1:0]         clr_addr;
  logic [AW-1:0]         j_q;
  logic [AW-1:0]         rd_addr_b_q;
  logic [ENT_W-1:0]      rd_a, rd_b;
  logic                  pend_valid;
  logic [AW-1:0]         pend_value;

  logic [AW-1:0]         out_pos_q, out_val_q;

  // slot memory with run tags
  logic [ENT_W-1:0]      slot_mem [MAX_LEN];

  // combinational signals
  logic                  cfg_wr;
  logic                  in_xfer;
  logic [AW-1:0]         mask;
  logic [AW-1:0]         j_new;
  logic                  reject;
  logic [AW-1:0]         rd_addr_b;
  logic                  run_end;
  logic                  rearm;
  logic [AW-1:0]         at_c, at_b;
  logic                  wr_en;
  logic [AW-1:0]         wr_addr;
  logic [ENT_W-1:0]      wr_data;
  logic                  load_out;
  logic [AW-1:0]         load_val;
  logic                  drain_pend;
  logic [31:0]           len_eff;
  logic [AW-1:0]         cursor_init;

  // configuration port
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready;
  assign prdata = (paddr == LEN_ADDR) ? {{(32 - LEN_W){1'b0}}, perm_length} : '0;

  // effective length from the value being written, else the current register value, saturated to 2..MAX_LEN
  always_comb begin
    logic [LEN_W-1:0] plen;
    plen = cfg_wr ? pwdata[LEN_W-1:0] : perm_length;
    len_eff = 32'(plen);
    if (len_eff < 32'd2) begin
      len_eff = 32'd2;
    end
    if (len_eff > 32'(MAX_LEN)) begin
      len_eff = 32'(MAX_LEN);
    end
    cursor_init = AW'(len_eff - 32'd1);
  end

  // mask: cursor smeared down from its top set bit
  always_comb begin
    mask = cursor;
    for (int s = 1; s < AW; s = s * 2) begin
      mask = mask | (mask >> s);
    end
  end

  assign j_new     = random_word[AW-1:0] & mask;
  assign reject    = (j_new > cursor);
  assign in_ready  = (state == ST_IDLE) && !pend_valid && (!out_valid || out_ready);
  assign in_xfer   = in_valid && in_ready;
  // at the final step port b fetches position 0 so both remaining slots are at hand
  assign rd_addr_b = (cursor == ONE_POS) ? '0 : j_new;

  // tagged read data: an entry from an older run reads as its own index
  assign at_c = (rd_a[ENT_W-1:AW] == epoch) ? rd_a[AW-1:0] : cursor;
  assign at_b = (rd_b[ENT_W-1:AW] == epoch) ? rd_b[AW-1:0] : rd_addr_b_q;

  assign run_end = (state == ST_SWAP) && (cursor == ONE_POS);
  assign rearm   = cfg_wr || run_end;

  // next state and datapath controls
  always_comb begin
    state_next = state;
    wr_en      = 1'b0;
    wr_addr    = j_q;
    wr_data    = {epoch, at_c};
    load_out   = 1'b0;
    load_val   = at_b;
    unique case (state)
      ST_CLEAR: begin
        wr_en   = 1'b1;
        wr_addr = clr_addr;
        wr_data = '0;
        if (clr_addr == LAST_ADDR) begin
          state_next = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (in_xfer && !reject) begin
          state_next = ST_SWAP;
        end
      end
      ST_SWAP: begin
        load_out   = 1'b1;
        state_next = ST_IDLE;
        if (cursor == ONE_POS) begin
          load_val = (j_q == '0) ? at_b : at_c;
        end else begin
          wr_en = 1'b1;
        end
      end
      default: begin
        state_next = ST_CLEAR;
      end
    endcase
    // a rearm that exhausts the tags starts a clearing pass
    if (rearm && state != ST_CLEAR && epoch == '1) begin
      state_next = ST_CLEAR;
    end
  end

  // memory write port and two read ports
  always_ff @(posedge clk) begin
    if (wr_en) begin
      slot_mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    rd_a        <= slot_mem[cursor];
    rd_b        <= slot_mem[rd_addr_b];
    rd_addr_b_q <= rd_addr_b;
    if (in_xfer) begin
      j_q <= j_new;
    end
  end

  // state register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_CLEAR;
    end else begin
      state <= state_next;
    end
  end

  // run control: length, cursor, tag and clearing address
  always_ff @(posedge clk) begin
    if (rst) begin
      perm_length <= LEN_W'(LEN_RESET);
      cursor      <= RESET_CURSOR;
      epoch       <= EPOCH_W'(1);
      clr_addr    <= '0;
    end else begin
      if (cfg_wr) begin
        perm_length <= pwdata[LEN_W-1:0];
      end
      if (state == ST_CLEAR) begin
        clr_addr <= clr_addr + ONE_POS;
      end
      if (rearm) begin
        cursor <= cursor_init;
        if (state != ST_CLEAR) begin
          if (epoch == '1) begin
            epoch    <= EPOCH_W'(1);
            clr_addr <= '0;
          end else begin
            epoch <= epoch + EPOCH_W'(1);
          end
        end
      end else if (load_out) begin
        cursor <= cursor - ONE_POS;
      end
    end
  end

  // output register and holding register for the final position
  assign drain_pend = pend_valid && (!out_valid || out_ready);

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      pend_valid <= 1'b0;
    end else begin
      if (load_out) begin
        out_valid  <= 1'b1;
        pend_valid <= run_end;
      end else if (drain_pend) begin
        out_valid  <= 1'b1;
        pend_valid <= 1'b0;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load_out) begin
      out_pos_q  <= cursor;
      out_val_q  <= load_val;
      last_slot  <= 1'b0;
      pend_value <= (j_q == '0) ? at_c : at_b;
    end else if (drain_pend) begin
      out_pos_q <= '0;
      out_val_q <= pend_value;
      last_slot <= 1'b1;
    end
  end

  // positions and values truncated or extended to the output field width
  always_comb begin
    logic [AW+FIELD_W-1:0] pos_ext, val_ext;
    pos_ext       = {{FIELD_W{1'b0}}, out_pos_q};
    val_ext       = {{FIELD_W{1'b0}}, out_val_q};
    slot_position = pos_ext[FIELD_W-1:0];
    slot_value    = val_ext[FIELD_W-1:0];
  end

endmodule

`default_nettype wire
